// ----- src/assert_macros.svh -----
// assertion helpers for the recency list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off during reset
`define CHECK_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs during reset
`define CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lru_pkg.sv -----
// ----------------------------------------------------------------------------
// lru_pkg
// types, codes and sizes shared by the recency list
// ----------------------------------------------------------------------------
package lru_pkg;

   localparam int ENTRIES    = 64;
   localparam int CHAR_BITS  = 16;
   localparam int SLOT_BITS  = 6;
   localparam int COUNT_BITS = 7;

   // operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_EVICT  = 2'd1;
   localparam logic [1:0] MODE_TOUCH  = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_NOT_USED = 2'd3;

   typedef struct packed {
      logic [1:0]           mode;
      logic [SLOT_BITS-1:0] slot_in;
      logic [15:0]          char_code;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_BITS-1:0]  slot_out;
      logic [15:0]           char_out;
      logic [SLOT_BITS-1:0]  head_slot;
      logic [SLOT_BITS-1:0]  tail_slot;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

endpackage

// ----- src/lru_recency_list.sv -----
// ----------------------------------------------------------------------------
// lru_recency_list
// recency list over a pool of slots, links and characters held in memories
// ----------------------------------------------------------------------------
// usage
//   a transaction is taken on a rising edge with start high and busy low;
//   req carries mode, slot and character code
//   each transaction gives one response, shown on rsp for exactly one cycle
//   with rsp_valid high; the receiver cannot stall it
//   insert, evict, clear and trivial touches respond from the execute state;
//   a touch that relinks goes on from there to the link state and responds
//   from it, since each link memory takes one write per cycle and both the
//   unlink and the relink write the next memory; a new transaction is taken
//   only once the response of the last one is registered
//   busy is high from acceptance until the cycle the response is registered
//   reset clears the in-use flags, head, tail and count at once; no sweep of
//   the memories is needed as values of unlinked entries are never used when read
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_recency_list
   import lru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_LINK  = 2'd2;

   logic [1:0]            state_ff, state_in;
   req_type               req_ff;
   logic [SLOT_BITS-1:0]  head_ff, head_in;
   logic [SLOT_BITS-1:0]  tail_ff, tail_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ENTRIES-1:0]    in_use_ff, in_use_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // link and character memories
   logic [SLOT_BITS-1:0] next_mem [ENTRIES];
   logic [SLOT_BITS-1:0] prev_mem [ENTRIES];
   logic [CHAR_BITS-1:0] char_mem [ENTRIES];

   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS-1:0] rd_next_ff, rd_prev_ff;
   logic [CHAR_BITS-1:0] rd_char_ff;

   logic                 next_we, prev_we, char_we;
   logic [SLOT_BITS-1:0] next_wa, next_wd, prev_wa, prev_wd, char_wa;

   logic [SLOT_BITS-1:0] free_slot;
   logic                 free_found;
   logic                 accept;

   assign accept  = start && (state_ff == ST_IDLE);
   assign rd_addr = (req.mode == MODE_EVICT) ? tail_ff : req.slot_in;

   // lowest free slot
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_slot  = SLOT_BITS'(i);
            free_found = 1'b1;
         end
      end
   end

   // synchronous memory read and write
   always_ff @(posedge clock) begin
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
      rd_char_ff <= char_mem[rd_addr];
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (char_we) char_mem[char_wa] <= req_ff.char_code[CHAR_BITS-1:0];
   end

   // operation sequencing
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      in_use_in    = in_use_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      next_we      = 1'b0;
      prev_we      = 1'b0;
      char_we      = 1'b0;
      next_wa      = '0;
      next_wd      = '0;
      prev_wa      = '0;
      prev_wd      = '0;
      char_wa      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_valid_in    = 1'b1;
            rsp_in.status   = STATUS_OK;
            rsp_in.slot_out = '0;
            rsp_in.char_out = '0;
            state_in        = ST_IDLE;
            case (req_ff.mode)
               MODE_INSERT: begin
                  if (!free_found) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     in_use_in[free_slot] = 1'b1;
                     char_we = 1'b1;
                     char_wa = free_slot;
                     next_we = 1'b1;
                     next_wa = free_slot;
                     next_wd = (count_ff == '0) ? '0 : head_ff;
                     if (count_ff == '0) begin
                        tail_in = free_slot;
                     end else begin
                        prev_we = 1'b1;
                        prev_wa = head_ff;
                        prev_wd = free_slot;
                     end
                     head_in  = free_slot;
                     count_in = count_ff + 1'b1;
                     rsp_in.slot_out = free_slot;
                  end
               end
               MODE_EVICT: begin
                  if (count_ff == '0) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else begin
                     rsp_in.slot_out = tail_ff;
                     rsp_in.char_out = 16'(rd_char_ff);
                     in_use_in[tail_ff] = 1'b0;
                     count_in = count_ff - 1'b1;
                     if (count_ff == COUNT_BITS'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        tail_in = rd_prev_ff;
                     end
                  end
               end
               MODE_TOUCH: begin
                  if (!in_use_ff[req_ff.slot_in]) begin
                     rsp_in.status = STATUS_NOT_USED;
                  end else if (count_ff > COUNT_BITS'(1) && req_ff.slot_in != head_ff) begin
                     // unlink the slot from its neighbours
                     next_we = 1'b1;
                     next_wa = rd_prev_ff;
                     next_wd = rd_next_ff;
                     if (req_ff.slot_in == tail_ff) begin
                        tail_in = rd_prev_ff;
                     end else begin
                        prev_we = 1'b1;
                        prev_wa = rd_next_ff;
                        prev_wd = rd_prev_ff;
                     end
                     rsp_valid_in = 1'b0;
                     state_in     = ST_LINK;
                  end
               end
               default: begin
                  in_use_in = '0;
                  head_in   = '0;
                  tail_in   = '0;
                  count_in  = '0;
               end
            endcase
         end
         ST_LINK: begin
            // link the touched slot in front of the old head
            next_we      = 1'b1;
            next_wa      = req_ff.slot_in;
            next_wd      = head_ff;
            prev_we      = 1'b1;
            prev_wa      = head_ff;
            prev_wd      = req_ff.slot_in;
            head_in      = req_ff.slot_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_in.head_slot   = head_in;
      rsp_in.tail_slot   = tail_in;
      rsp_in.entry_count = count_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `CHECK_PROP(a_count_matches_flags, clock, reset, count_ff == COUNT_BITS'($countones(in_use_ff)), "entry count disagrees with in-use flags")
   `CHECK_PROP(a_accept_goes_busy, clock, reset, accept |=> busy, "transaction taken but block not busy")
   `CHECK_PROP(a_full_means_all_used, clock, reset, (rsp_valid && rsp.status == STATUS_FULL) |-> (rsp.entry_count == COUNT_BITS'(ENTRIES)), "full status with free slots")
   `CHECK_PROP(a_empty_pointers_zero, clock, reset, (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0), "empty list with stale pointers")

endmodule

// ----- verif/lru_recency_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_recency_list_tb
// self-checking bench for the slot recency list: a behavioural copy of the
// list predicts every response, random and directed traffic with idle gaps
// ----------------------------------------------------------------------------
module lru_recency_list_tb;
   import lru_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   lru_recency_list dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   // clock
   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // predicted list state
   logic                 slot_busy [ENTRIES];
   logic [SLOT_BITS-1:0] nxt [ENTRIES];
   logic [SLOT_BITS-1:0] prv [ENTRIES];
   logic [15:0]          chars [ENTRIES];
   logic [SLOT_BITS-1:0] head_p, tail_p;
   int                   live;

   rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      sent = 0;
   int      n_full = 0, n_empty = 0, n_unused = 0, n_relink = 0;
   bit      calm = 0;

   function automatic rsp_type list_update(req_type r);
      rsp_type o;
      int s;
      logic [SLOT_BITS-1:0] p, n;
      o = '0;
      o.status = STATUS_OK;
      case (r.mode)
         MODE_INSERT: begin
            if (live >= ENTRIES) begin
               o.status = STATUS_FULL; n_full++;
            end else begin
               for (s = 0; s < ENTRIES; s++) if (!slot_busy[s]) break;
               slot_busy[s] = 1; chars[s] = r.char_code; prv[s] = '0;
               if (live == 0) begin
                  nxt[s] = '0; tail_p = SLOT_BITS'(s);
               end else begin
                  nxt[s] = head_p; prv[head_p] = SLOT_BITS'(s);
               end
               head_p = SLOT_BITS'(s); live++; o.slot_out = SLOT_BITS'(s);
            end
         end
         MODE_EVICT: begin
            if (live == 0) begin
               o.status = STATUS_EMPTY; n_empty++;
            end else begin
               s = tail_p; o.slot_out = SLOT_BITS'(s); o.char_out = chars[s];
               slot_busy[s] = 0; live--;
               if (live == 0) begin
                  head_p = '0; tail_p = '0;
               end else tail_p = prv[s];
            end
         end
         MODE_TOUCH: begin
            s = r.slot_in;
            if (!slot_busy[s]) begin
               o.status = STATUS_NOT_USED; n_unused++;
            end else if (live > 1 && s != head_p) begin
               p = prv[s]; n = nxt[s]; nxt[p] = n;
               if (s == tail_p) tail_p = p; else prv[n] = p;
               prv[s] = '0; nxt[s] = head_p; prv[head_p] = SLOT_BITS'(s);
               head_p = SLOT_BITS'(s);
               n_relink++;
            end
         end
         default: begin
            foreach (slot_busy[i]) slot_busy[i] = 0;
            head_p = '0; tail_p = '0; live = 0;
         end
      endcase
      o.head_slot   = live ? head_p : '0;
      o.tail_slot   = live ? tail_p : '0;
      o.entry_count = COUNT_BITS'(live);
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp);
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_r, rsp);
            end
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("[lru_recency_list] ERROR");
         $finish;
      end
   end

   // send one transaction, with random idle gaps unless calm
   // start stays high after the transaction until the next idle or drain
   task automatic send_op(logic [1:0] m, logic [5:0] s, logic [15:0] c);
      while (!calm && $urandom_range(99) < 31) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req <= '{mode: m, slot_in: s, char_code: c};
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(list_update(req));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_op(MODE_EVICT, 6'd0, 16'h0);
      send_op(MODE_TOUCH, 6'd5, 16'h0);
      send_op(MODE_INSERT, 6'h3f, 16'hffff);
      send_op(MODE_TOUCH, 6'd0, 16'h0);
      send_op(MODE_INSERT, 6'd0, 16'h0000);
      send_op(MODE_INSERT, 6'd0, 16'h5a5a);
      send_op(MODE_TOUCH, 6'd0, 16'h0);
      send_op(MODE_TOUCH, 6'd1, 16'h0);
      send_op(MODE_TOUCH, 6'd63, 16'h0);
      send_op(MODE_EVICT, 6'd0, 16'h0);
      send_op(MODE_EVICT, 6'd0, 16'h0);
      send_op(MODE_EVICT, 6'd0, 16'h0);
      send_op(MODE_EVICT, 6'd0, 16'h0);
      send_op(MODE_INSERT, 6'd0, 16'h1234);
      send_op(MODE_CLEAR, 6'd0, 16'h0);
      send_op(MODE_EVICT, 6'd0, 16'h0);
   endtask

   // fill the pool to capacity and overflow it, relink a few, then drain it past empty
   task automatic test_full_pool();
      for (int i = 0; i < ENTRIES + 2; i++)
         send_op(MODE_INSERT, 6'($urandom), 16'($urandom));
      send_op(MODE_TOUCH, 6'd0, 16'h0);
      send_op(MODE_TOUCH, 6'd63, 16'h0);
      send_op(MODE_TOUCH, 6'd31, 16'h0);
      for (int i = 0; i < ENTRIES + 1; i++) send_op(MODE_EVICT, 6'd0, 16'h0);
   endtask

   // random mix weighted towards a populated list
   task automatic test_random(int n);
      logic [1:0] m;
      int r;
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 3 && i < n / 3 + 150);
         r = $urandom_range(99);
         if (r < 40) m = MODE_INSERT;
         else if (r < 65) m = MODE_EVICT;
         else if (r < 98) m = MODE_TOUCH;
         else m = MODE_CLEAR;
         send_op(m, (live > 0 && $urandom_range(3) != 0) ?
                 6'($urandom_range(live + 2)) : 6'($urandom), 16'($urandom));
         if (i == n / 2) drain();
      end
      calm = 0;
   endtask

   initial begin
      reset = 1'b1; start = 1'b0; req = '0;
      foreach (slot_busy[i]) slot_busy[i] = 0;
      head_p = '0; tail_p = '0; live = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_pool();
      test_random(1100);
      drain();
      repeat (10) @(negedge clock);
      $display("%0d transactions: %0d full, %0d empty, %0d unused, %0d relinks",
               sent, n_full, n_empty, n_unused, n_relink);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("[lru_recency_list] OK");
      else
         $display("[lru_recency_list] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/lru_pkg.sv
src/lru_recency_list.sv
verif/lru_recency_list_tb.sv
